// ===== sv/vrr_pkg.sv =====
package vrr_pkg;

	localparam int VERTEX_W = 32;
	localparam int INDEX_W  = 7;
	localparam int POS_W    = 6;
	localparam int LEN_W    = 7;
	localparam int CMD_W    = 3;
	localparam int STAT_W   = 3;

	localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FIND    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] ST_ENDS_EQ   = 3'd3;
	localparam logic [STAT_W-1:0] ST_ENDS_GONE = 3'd4;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [VERTEX_W-1:0] vertex;
		logic [INDEX_W-1:0]  index;
		logic [VERTEX_W-1:0] first_vertex;
		logic [VERTEX_W-1:0] last_vertex;
	} vrr_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [POS_W-1:0]    position;
		logic [VERTEX_W-1:0] read_value;
		logic [LEN_W-1:0]    ring_length;
	} vrr_res_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INS,
		OP_DEL,
		OP_WR
	} ring_op_t;

	typedef struct packed {
		ring_op_t            op;
		logic [VERTEX_W-1:0] value;
	} ring_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FINDW,
		S_PLAN,
		S_RUN,
		S_DONE
	} vrr_state_t;

endpackage

// ===== sv/vrr_cell.sv =====
module vrr_cell #(
	parameter int POS_BITS = 7,
	parameter int CELL_IDX = 0
) (
	input  logic                     clk,
	input  vrr_pkg::ring_ctl_t       ctl,
	input  logic [POS_BITS-1:0]      pos,
	input  logic [vrr_pkg::VERTEX_W-1:0] left_in,
	input  logic [vrr_pkg::VERTEX_W-1:0] right_in,
	input  logic [vrr_pkg::VERTEX_W-1:0] key_a,
	input  logic [vrr_pkg::VERTEX_W-1:0] key_b,
	output logic [vrr_pkg::VERTEX_W-1:0] entry,
	output logic                     hit_a,
	output logic                     hit_b
);
	import vrr_pkg::*;

	localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(CELL_IDX);

	logic [VERTEX_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INS: begin
				if (MY_POS > pos) entry_q <= left_in;
				else if (MY_POS == pos) entry_q <= ctl.value;
			end
			OP_DEL: begin
				if (MY_POS >= pos) entry_q <= right_in;
			end
			OP_WR: begin
				if (MY_POS == pos) entry_q <= ctl.value;
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign hit_a = (entry_q == key_a);
	assign hit_b = (entry_q == key_b);

endmodule

// ===== sv/vertex_ring_range_replace.sv =====
// Each command passes S_PLAN, S_RUN and S_DONE; range replace first visits S_FINDW.
// S_RUN applies planned inserts, then removals, then the write, one cell shift per cycle.
// Throughput: one command at a time; busy stays high until the done beat.
// The done beat lasts one cycle and the receiver cannot stall it.
// Reset (arst_n low) empties the ring; entry storage itself is not cleared.
module vertex_ring_range_replace #(
	parameter int RING_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  vrr_pkg::vrr_cmd_t command,
	output logic              done,
	output vrr_pkg::vrr_res_t result
);
	import vrr_pkg::*;

	localparam int IW   = $clog2(RING_DEPTH);
	localparam int CW   = $clog2(RING_DEPTH + 1);
	localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam logic [CW:0] DEPTH_X = (CW + 1)'(RING_DEPTH);

	vrr_state_t state_q, state_d;

	vrr_cmd_t          cmd_q, cmd_d;
	logic [CW-1:0]     count_q, count_d;
	logic              rem_q, rem_d;
	logic [CW-1:0]     wi_q, wi_d;
	logic [CW-1:0]     ins_pos_q [3];
	logic [CW-1:0]     ins_pos_d [3];
	logic [VERTEX_W-1:0] ins_val_q [3];
	logic [VERTEX_W-1:0] ins_val_d [3];
	logic [1:0]        ins_n_q, ins_n_d, ins_idx_q, ins_idx_d;
	logic [CW-1:0]     del_n_q, del_n_d, del_pos_q, del_pos_d;
	logic              wr_en_q, wr_en_d, len_en_q, len_en_d;
	logic [CW-1:0]     wr_pos_q, wr_pos_d, len_q, len_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic [IW-1:0]     fpos_q, fpos_d;
	logic [VERTEX_W-1:0] rd_q, rd_d;

	ring_ctl_t           ctl;
	logic [CW-1:0]       op_pos;
	logic [VERTEX_W-1:0] key_a;
	logic [VERTEX_W-1:0] entries [RING_DEPTH];
	logic [RING_DEPTH-1:0] raw_a, raw_b, hit_a, hit_b;
	logic [IW-1:0]       pa, pb;

	genvar g;
	generate
		for (g = 0; g < RING_DEPTH; g++) begin : g_cell
			vrr_cell #(.POS_BITS(CW), .CELL_IDX(g)) u_cell (
				.clk      (clk),
				.ctl      (ctl),
				.pos      (op_pos),
				.left_in  ((g == 0) ? '0 : entries[(g == 0) ? 0 : g - 1]),
				.right_in (entries[(g == RING_DEPTH - 1) ? g : g + 1]),
				.key_a    (key_a),
				.key_b    (cmd_q.last_vertex),
				.entry    (entries[g]),
				.hit_a    (raw_a[g]),
				.hit_b    (raw_b[g])
			);
			assign hit_a[g] = raw_a[g] && (CW'(g) < count_q);
			assign hit_b[g] = raw_b[g] && (CW'(g) < count_q);
		end
	endgenerate

	assign key_a = (state_q == S_FINDW ||
		(state_q == S_PLAN && cmd_q.cmd == CMD_FIND)) ? cmd_q.vertex : cmd_q.first_vertex;

	// first hit wins
	always_comb begin
		pa = '0;
		pb = '0;
		for (int i = RING_DEPTH - 1; i >= 0; i--) begin
			if (hit_a[i]) pa = IW'(i);
			if (hit_b[i]) pb = IW'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ins_n_q   <= '0;
			ins_idx_q <= '0;
			del_n_q   <= '0;
			wr_en_q   <= 1'b0;
			len_en_q  <= 1'b0;
			rem_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			ins_n_q   <= ins_n_d;
			ins_idx_q <= ins_idx_d;
			del_n_q   <= del_n_d;
			wr_en_q   <= wr_en_d;
			len_en_q  <= len_en_d;
			rem_q     <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q     <= cmd_d;
		wi_q      <= wi_d;
		ins_pos_q <= ins_pos_d;
		ins_val_q <= ins_val_d;
		del_pos_q <= del_pos_d;
		wr_pos_q  <= wr_pos_d;
		len_q     <= len_d;
		status_q  <= status_d;
		fpos_q    <= fpos_d;
		rd_q      <= rd_d;
	end

	always_comb begin
		logic [CMPW-1:0] idx_x, cnt_x;
		logic [CW-1:0]   a_w, b_w;
		logic [CW:0]     n_x;

		state_d   = state_q;
		cmd_d     = cmd_q;
		count_d   = count_q;
		rem_d     = rem_q;
		wi_d      = wi_q;
		ins_pos_d = ins_pos_q;
		ins_val_d = ins_val_q;
		ins_n_d   = ins_n_q;
		ins_idx_d = ins_idx_q;
		del_n_d   = del_n_q;
		del_pos_d = del_pos_q;
		wr_en_d   = wr_en_q;
		wr_pos_d  = wr_pos_q;
		len_en_d  = len_en_q;
		len_d     = len_q;
		status_d  = status_q;
		fpos_d    = fpos_q;
		rd_d      = rd_q;
		ctl.op    = OP_NONE;
		ctl.value = cmd_q.vertex;
		op_pos    = '0;

		idx_x = CMPW'(cmd_q.index);
		cnt_x = CMPW'(count_q);
		a_w   = CW'(pa);
		b_w   = CW'(pb);
		n_x   = {1'b0, count_q};

		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_d     = command;
					rem_d     = 1'b0;
					ins_n_d   = '0;
					ins_idx_d = '0;
					del_n_d   = '0;
					wr_en_d   = 1'b0;
					len_en_d  = 1'b0;
					status_d  = ST_OK;
					fpos_d    = '0;
					rd_d      = '0;
					state_d   = (command.cmd == CMD_REPLACE) ? S_FINDW : S_PLAN;
				end
			end
			S_FINDW: begin
				// drop w first; the plan sees the ring without it
				if (|hit_a) begin
					ctl.op  = OP_DEL;
					op_pos  = CW'(pa);
					count_d = count_q - 1'b1;
					rem_d   = 1'b1;
					wi_d    = CW'(pa);
				end
				state_d = S_PLAN;
			end
			S_PLAN: begin
				state_d = S_RUN;
				case (cmd_q.cmd)
					CMD_INSERT: begin
						if (idx_x > cnt_x) status_d = ST_BAD_INDEX;
						else if (n_x >= DEPTH_X) status_d = ST_FULL;
						else begin
							ins_pos_d[0] = CW'(cmd_q.index);
							ins_val_d[0] = cmd_q.vertex;
							ins_n_d      = 2'd1;
						end
					end
					CMD_REMOVE: begin
						if (idx_x >= cnt_x) status_d = ST_BAD_INDEX;
						else begin
							del_pos_d = CW'(cmd_q.index);
							del_n_d   = CW'(1);
						end
					end
					CMD_FIND: begin
						if (|hit_a) fpos_d = pa;
						else status_d = ST_NOT_FOUND;
					end
					CMD_CLEAR: begin
						count_d = '0;
					end
					CMD_READ: begin
						if (idx_x >= cnt_x) status_d = ST_BAD_INDEX;
						else rd_d = entries[cmd_q.index[IW-1:0]];
					end
					CMD_REPLACE: begin
						if (count_q == '0) begin
							ins_pos_d[0] = CW'(0);
							ins_val_d[0] = cmd_q.first_vertex;
							ins_pos_d[1] = CW'(1);
							ins_val_d[1] = cmd_q.vertex;
							ins_pos_d[2] = CW'(2);
							ins_val_d[2] = cmd_q.last_vertex;
							ins_n_d = (cmd_q.first_vertex != cmd_q.last_vertex) ? 2'd3 : 2'd2;
						end else if (cmd_q.first_vertex == cmd_q.last_vertex) begin
							status_d = ST_ENDS_EQ;
						end else if (!(|hit_a) && !(|hit_b)) begin
							status_d = ST_ENDS_GONE;
						end else if (!(|hit_a)) begin
							if (n_x + 2'd2 > DEPTH_X) status_d = ST_FULL;
							else begin
								ins_pos_d[0] = b_w;
								ins_val_d[0] = cmd_q.vertex;
								ins_pos_d[1] = b_w;
								ins_val_d[1] = cmd_q.first_vertex;
								ins_n_d = 2'd2;
							end
						end else if (!(|hit_b)) begin
							if (n_x + 2'd2 > DEPTH_X) status_d = ST_FULL;
							else begin
								ins_pos_d[0] = a_w + 1'b1;
								ins_val_d[0] = cmd_q.last_vertex;
								ins_pos_d[1] = a_w + 1'b1;
								ins_val_d[1] = cmd_q.vertex;
								ins_n_d = 2'd2;
							end
						end else if ((a_w + 1'b1 == b_w) ||
							(a_w == count_q - 1'b1 && b_w == '0)) begin
							if (n_x + 1'b1 > DEPTH_X) status_d = ST_FULL;
							else begin
								ins_pos_d[0] = a_w + 1'b1;
								ins_val_d[0] = cmd_q.vertex;
								ins_n_d = 2'd1;
							end
						end else if (a_w < b_w) begin
							del_pos_d = a_w + 2'd2;
							del_n_d   = b_w - a_w - 2'd2;
							wr_en_d   = 1'b1;
							wr_pos_d  = a_w + 1'b1;
						end else if (b_w == CW'(1)) begin
							wr_en_d  = 1'b1;
							wr_pos_d = '0;
							len_en_d = 1'b1;
							len_d    = a_w + 1'b1;
						end else begin
							del_pos_d = '0;
							del_n_d   = b_w;
							wr_en_d   = 1'b1;
							wr_pos_d  = a_w - b_w + 1'b1;
							len_en_d  = 1'b1;
							len_d     = a_w - b_w + 2'd2;
						end
						// a full ring leaves no trace: put w back where it was
						if (status_d == ST_FULL && rem_q) begin
							ins_pos_d[0] = wi_q;
							ins_val_d[0] = cmd_q.vertex;
							ins_n_d = 2'd1;
						end
					end
					default: begin
					end
				endcase
			end
			S_RUN: begin
				if (ins_idx_q < ins_n_q) begin
					ctl.op    = OP_INS;
					op_pos    = ins_pos_q[ins_idx_q];
					ctl.value = ins_val_q[ins_idx_q];
					count_d   = count_q + 1'b1;
					ins_idx_d = ins_idx_q + 1'b1;
				end else if (del_n_q != '0) begin
					ctl.op  = OP_DEL;
					op_pos  = del_pos_q;
					count_d = count_q - 1'b1;
					del_n_d = del_n_q - 1'b1;
				end else if (wr_en_q) begin
					ctl.op  = OP_WR;
					op_pos  = wr_pos_q;
					wr_en_d = 1'b0;
					if (len_en_q) count_d = len_q;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign result.status      = status_q;
	assign result.position    = POS_W'(fpos_q);
	assign result.read_value  = rd_q;
	assign result.ring_length = LEN_W'(count_q);

`ifndef SYNTHESIS
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done)) else $error("busy dropped without a done beat");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done beat while idle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted beat did not raise busy");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= DEPTH_X) else $error("ring count past depth");
`endif

endmodule
